// ===== hw/rtl/inode_bitmap_allocator_with_name_check_unit_defines.svh =====
// ----------------------------------------------------------------------------
// inode allocator assertion macros
// concurrent checks on clock, switched off for synthesis
// ----------------------------------------------------------------------------
`ifndef INODE_BITMAP_ALLOCATOR_WITH_NAME_CHECK_UNIT_DEFINES_SVH
`define INODE_BITMAP_ALLOCATOR_WITH_NAME_CHECK_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// check held outside reset
`define IBA_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("iba assertion failed");
// check held at every edge, reset included
`define IBA_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) prop) \
      else $error("iba assertion failed");
`else
`define IBA_ASSERT(lbl, prop)
`define IBA_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

// ===== hw/rtl/iba_pkg.sv =====
// ----------------------------------------------------------------------------
// iba_pkg
// shared constants, codes and control types of the inode allocator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package iba_pkg;

   localparam int ENTRIES    = 1024;
   localparam int IDX_W      = $clog2(ENTRIES);
   localparam int CNT_W      = $clog2(ENTRIES + 1);
   localparam int NAME_BYTES = 8;
   localparam int NAME_W     = 8 * NAME_BYTES;
   localparam int LEN_W      = 8;
   localparam int CREATED_W  = 16;

   typedef enum logic [1:0] {
      ST_CREATED  = 2'd0,
      ST_TOO_LONG = 2'd1,
      ST_EXISTS   = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DONE
   } state_type;

   typedef struct packed {
      logic       capture;
      logic       scan;
      logic       load_rsp;
      status_type rsp_status;
   } cmd_type;

   typedef struct packed {
      logic too_long;
      logic hit;
      logic scan_done;
      logic blank_free;
      logic full;
      logic rsp_busy;
   } sts_type;

endpackage

// ===== hw/rtl/iba_datapath.sv =====
// ----------------------------------------------------------------------------
// iba_datapath
// name store, fill count, counters, scan compare and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "inode_bitmap_allocator_with_name_check_unit_defines.svh"

module iba_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  iba_pkg::cmd_type              cmd,
   output iba_pkg::sts_type              sts,
   input  logic [iba_pkg::NAME_W-1:0]    req_name_bytes,
   input  logic [iba_pkg::LEN_W-1:0]     req_name_length,
   input  logic                          csr_wr_en,
   input  logic [iba_pkg::CNT_W-1:0]     csr_wr_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic [iba_pkg::IDX_W-1:0]     rsp_entry_index,
   output logic [iba_pkg::CNT_W-1:0]     rsp_free_entries,
   output logic [iba_pkg::CREATED_W-1:0] rsp_created_total
);

   // name ends at its length or at its first zero byte
   function automatic logic [iba_pkg::NAME_W-1:0] trim_name(
      input logic [iba_pkg::NAME_W-1:0] raw,
      input logic [iba_pkg::LEN_W-1:0]  len
   );
      logic                         live;
      logic [iba_pkg::NAME_W-1:0]   res;
      live = 1'b1;
      res  = '0;
      for (int b = 0; b < iba_pkg::NAME_BYTES; b++) begin
         if (len <= iba_pkg::LEN_W'(b)) begin
            live = 1'b0;
         end
         if (raw[8*b +: 8] == 8'h00) begin
            live = 1'b0;
         end
         if (live) begin
            res[8*b +: 8] = raw[8*b +: 8];
         end
      end
      return res;
   endfunction

   logic [iba_pkg::NAME_W-1:0]    name_mem [iba_pkg::ENTRIES];

   logic [iba_pkg::NAME_W-1:0]    name_ff;
   logic [iba_pkg::NAME_W-1:0]    rd_data_ff;
   logic [iba_pkg::CNT_W-1:0]     used_count_ff, used_count_in;
   logic [iba_pkg::CNT_W-1:0]     free_ff, free_in;
   logic [iba_pkg::CREATED_W-1:0] created_ff, created_in;
   logic [iba_pkg::IDX_W-1:0]     scan_addr_ff, scan_addr_in;
   logic                          issue_ff, issue_in;
   logic                          cmp_valid_ff, cmp_valid_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [1:0]                    rsp_status_ff;
   logic [iba_pkg::IDX_W-1:0]     rsp_index_ff;
   logic [iba_pkg::CNT_W-1:0]     rsp_free_ff;
   logic [iba_pkg::CREATED_W-1:0] rsp_created_ff;

   logic                          mem_we;
   logic                          full;
   logic [iba_pkg::CNT_W-1:0]     free_dec;
   logic [iba_pkg::CNT_W-1:0]     scan_next;

   assign full      = (used_count_ff == iba_pkg::CNT_W'(iba_pkg::ENTRIES));
   assign mem_we    = cmd.load_rsp && (cmd.rsp_status == iba_pkg::ST_CREATED);
   assign free_dec  = (free_ff != '0) ? free_ff - 1'b1 : free_ff;
   assign scan_next = {1'b0, scan_addr_ff} + 1'b1;

   assign sts.too_long   = (req_name_length > iba_pkg::LEN_W'(iba_pkg::NAME_BYTES));
   assign sts.hit        = cmp_valid_ff && (rd_data_ff == name_ff);
   assign sts.scan_done  = !issue_ff && !cmp_valid_ff;
   // entries past the fill count still hold the empty name
   assign sts.blank_free = (name_ff == '0) && !full;
   assign sts.full       = full;
   assign sts.rsp_busy   = rsp_valid_ff && !rsp_ready;

   always_comb begin
      used_count_in = used_count_ff;
      free_in       = free_ff;
      created_in    = created_ff;
      scan_addr_in  = scan_addr_ff;
      issue_in      = 1'b0;
      cmp_valid_in  = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      if (cmd.capture) begin
         scan_addr_in = '0;
         issue_in     = (used_count_ff != '0);
      end else if (cmd.scan) begin
         cmp_valid_in = issue_ff;
         issue_in     = issue_ff;
         if (issue_ff) begin
            scan_addr_in = scan_next[iba_pkg::IDX_W-1:0];
            issue_in     = (scan_next < used_count_ff);
         end
      end

      if (mem_we) begin
         used_count_in = used_count_ff + 1'b1;
         free_in       = free_dec;
         created_in    = created_ff + 1'b1;
      end
      if (csr_wr_en) begin
         free_in = (csr_wr_data > iba_pkg::CNT_W'(iba_pkg::ENTRIES)) ?
                   iba_pkg::CNT_W'(iba_pkg::ENTRIES) : csr_wr_data;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_count_ff <= '0;
         free_ff       <= iba_pkg::CNT_W'(iba_pkg::ENTRIES);
         created_ff    <= '0;
         scan_addr_ff  <= '0;
         issue_ff      <= 1'b0;
         cmp_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         used_count_ff <= used_count_in;
         free_ff       <= free_in;
         created_ff    <= created_in;
         scan_addr_ff  <= scan_addr_in;
         issue_ff      <= issue_in;
         cmp_valid_ff  <= cmp_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         name_ff <= trim_name(req_name_bytes, req_name_length);
      end
      if (cmd.load_rsp) begin
         rsp_status_ff  <= cmd.rsp_status;
         rsp_index_ff   <= mem_we ? used_count_ff[iba_pkg::IDX_W-1:0] : '0;
         rsp_free_ff    <= mem_we ? free_dec : free_ff;
         rsp_created_ff <= mem_we ? created_ff + 1'b1 : created_ff;
      end
   end

   // name store: one write port at the fill count, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         name_mem[used_count_ff[iba_pkg::IDX_W-1:0]] <= name_ff;
      end
      rd_data_ff <= name_mem[scan_addr_ff];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_entry_index   = rsp_index_ff;
   assign rsp_free_entries  = rsp_free_ff;
   assign rsp_created_total = rsp_created_ff;

   `IBA_ASSERT(a_no_write_when_full, mem_we |-> !full)
   `IBA_ASSERT(a_free_never_rises, !csr_wr_en |=> (free_ff <= $past(free_ff)))
   `IBA_ASSERT(a_compare_after_read, cmp_valid_ff |-> $past(issue_ff))
   `IBA_ASSERT(a_created_steps, mem_we |=> (created_ff == iba_pkg::CREATED_W'($past(created_ff) + 1'b1)))

endmodule

// ===== hw/rtl/iba_ctrl.sv =====
// ----------------------------------------------------------------------------
// iba_ctrl
// sequencer: accept, scan the store unless too long, then hand off one result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iba_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  iba_pkg::sts_type sts,
   output iba_pkg::cmd_type cmd
);

   iba_pkg::state_type  state_ff, state_in;
   iba_pkg::status_type status_ff, status_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= iba_pkg::S_IDLE;
         status_ff <= iba_pkg::ST_CREATED;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      status_in      = status_ff;
      req_ready      = 1'b0;
      cmd.capture    = 1'b0;
      cmd.scan       = 1'b0;
      cmd.load_rsp   = 1'b0;
      cmd.rsp_status = status_ff;

      unique case (state_ff)
         iba_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (sts.too_long) begin
                  status_in = iba_pkg::ST_TOO_LONG;
                  state_in  = iba_pkg::S_DONE;
               end else begin
                  state_in  = iba_pkg::S_SCAN;
               end
            end
         end
         iba_pkg::S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.hit) begin
               status_in = iba_pkg::ST_EXISTS;
               state_in  = iba_pkg::S_DONE;
            end else if (sts.scan_done) begin
               if (sts.blank_free) begin
                  status_in = iba_pkg::ST_EXISTS;
               end else if (sts.full) begin
                  status_in = iba_pkg::ST_FULL;
               end else begin
                  status_in = iba_pkg::ST_CREATED;
               end
               state_in = iba_pkg::S_DONE;
            end
         end
         iba_pkg::S_DONE: begin
            if (!sts.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = iba_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = iba_pkg::S_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/inode_bitmap_allocator_with_name_check_unit.sv =====
// flow: one item at a time, the next item is taken as the result shows;
// a too-long name skips the scan, else the name scan reads one entry a cycle
// over the allocated entries, and a name match ends it early
// reset: synchronous active high; store reads as empty and all entries free at once
// ----------------------------------------------------------------------------
// inode_bitmap_allocator_with_name_check_unit
// create requests: reject long names and duplicates, and report full when no
// entry is left, else take the lowest free entry, store the name, report counters
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module inode_bitmap_allocator_with_name_check_unit (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [iba_pkg::NAME_W-1:0]    req_name_bytes,
   input  logic [iba_pkg::LEN_W-1:0]     req_name_length,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic [iba_pkg::IDX_W-1:0]     rsp_entry_index,
   output logic [iba_pkg::CNT_W-1:0]     rsp_free_entries,
   output logic [iba_pkg::CREATED_W-1:0] rsp_created_total,
   // free count load
   input  logic                          csr_wr_en,
   input  logic [iba_pkg::CNT_W-1:0]     csr_wr_data
);

   // how it works:
   // - entries are only ever taken lowest first and never freed, so the used
   //   map is always a filled prefix; a fill count stands for it, its value
   //   is the lowest free index and entries above it read as the empty name
   // - the duplicate check walks the filled entries one read a cycle and
   //   stops at the first match
   // - an empty name matches any entry still unfilled
   // - the result register lets a new item in while the last result waits

   iba_pkg::cmd_type cmd;
   iba_pkg::sts_type sts;

   // sequencer
   iba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // name store, counters and result register
   iba_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_name_bytes    (req_name_bytes),
      .req_name_length   (req_name_length),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_entry_index   (rsp_entry_index),
      .rsp_free_entries  (rsp_free_entries),
      .rsp_created_total (rsp_created_total)
   );

endmodule
